// File: src/bfa_pkg.sv
// Shared types and constants for the best-fit boundary-tag allocator.
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int TAG_W  = 16;  // one boundary tag per heap word
    localparam int POS_W  = 16;  // word positions plus block lengths, with headroom
    localparam int REQ_W  = 13;
    localparam int OFF_W  = 12;
    localparam int NEED_W = 14;  // rounded request plus header, in bytes

    localparam logic [TAG_W-1:0] TAG_BUSY      = 16'h0001;
    localparam logic [TAG_W-1:0] TAG_PREV_BUSY = 16'h0002;
    localparam logic [TAG_W-1:0] TAG_SIZE_MASK = 16'hFFFC;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_WALK,
        ST_A_FIN,
        ST_A_SPLIT,
        ST_A_FOOT,
        ST_F_HDR,
        ST_F_PREV,
        ST_F_NEXT,
        ST_F_WH,
        ST_F_WF,
        ST_F_CN,
        ST_RESP
    } bfa_state_t;

    typedef struct packed {
        logic             opcode;
        logic [REQ_W-1:0] request_size;
        logic [OFF_W-1:0] payload_offset;
    } bfa_cmd_t;

    typedef struct packed {
        logic             valid;
        logic             status;
        logic [OFF_W-1:0] offset;
    } bfa_resp_t;

endpackage

// File: src/bfa_tag_ram.sv
// Tag memory: one write port and one registered read port.
`timescale 1ns / 1ps

module bfa_tag_ram #(
    parameter int HEAP_WORDS = 1024
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(HEAP_WORDS)-1:0] wr_addr,
    input  logic [bfa_pkg::TAG_W-1:0]     wr_data,
    input  logic [$clog2(HEAP_WORDS)-1:0] rd_addr,
    output logic [bfa_pkg::TAG_W-1:0]     rd_data
);

    logic [bfa_pkg::TAG_W-1:0] mem [HEAP_WORDS];
    logic [bfa_pkg::TAG_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/bfa_seq.sv
// Sequencer and shared datapath that walk and rewrite the boundary tags.
`timescale 1ns / 1ps

module bfa_seq #(
    parameter int HEAP_WORDS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  bfa_pkg::bfa_cmd_t             cmd,
    input  logic                          out_free,
    output logic                          seq_ready,
    output bfa_pkg::bfa_resp_t            resp,
    output logic                          wr_en,
    output logic [$clog2(HEAP_WORDS)-1:0] wr_addr,
    output logic [bfa_pkg::TAG_W-1:0]     wr_data,
    output logic [$clog2(HEAP_WORDS)-1:0] rd_addr,
    input  logic [bfa_pkg::TAG_W-1:0]     rd_data
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int TW = bfa_pkg::TAG_W;
    localparam int PW = bfa_pkg::POS_W;
    localparam int NW = bfa_pkg::NEED_W;
    localparam int OW = bfa_pkg::OFF_W;
    localparam logic [PW-1:0] HW_POS    = PW'(HEAP_WORDS);
    localparam logic [PW-1:0] HB_POS    = PW'(HEAP_WORDS * 4);
    localparam logic [TW-1:0] HB_TAG    = TW'(HEAP_WORDS * 4);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HEAP_WORDS - 1);

    bfa_pkg::bfa_state_t state_reg, state_next;

    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic           op_reg, op_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [NW-1:0]  need_reg, need_next;
    logic [AW-1:0]  best_reg, best_next;
    logic [TW-1:0]  best_diff_reg, best_diff_next;
    logic           best_pred_reg, best_pred_next;
    logic           pred_reg, pred_next;
    logic           found_reg, found_next;
    logic [PW-1:0]  nxt_reg, nxt_next;
    logic [PW-1:0]  h_reg, h_next;
    logic [PW-1:0]  head_reg, head_next;
    logic [PW-1:0]  foot_reg, foot_next;
    logic [TW-1:0]  total_reg, total_next;
    logic           res_status_reg, res_status_next;
    logic [OW-1:0]  res_off_reg, res_off_next;

    logic [TW-1:0]  tag_size;
    logic [PW-1:0]  tag_words;
    logic [PW-1:0]  pos_sum;
    logic [TW:0]    fit_diff;
    logic           fits;
    logic [NW-1:0]  need_calc;
    logic [PW-1:0]  free_h;
    logic           free_ok;
    logic [PW-1:0]  nxt_end;
    logic [PW-1:0]  split_foot;
    logic [PW-1:0]  foot_succ;
    logic [TW-1:0]  pred_tag;

    // Shared datapath terms, most of them driven from the tag just read.
    assign tag_size  = rd_data & bfa_pkg::TAG_SIZE_MASK;
    assign tag_words = PW'(tag_size >> 2);
    assign pos_sum   = pos_reg + tag_words;
    assign fit_diff  = {1'b0, tag_size} - {{(TW + 1 - NW){1'b0}}, need_reg};
    assign fits      = !fit_diff[TW];
    assign nxt_end   = nxt_reg + tag_words;
    assign split_foot = nxt_reg + PW'(best_diff_reg >> 2) - PW'(1);
    assign foot_succ = foot_reg + PW'(1);
    assign pred_tag  = pred_reg ? bfa_pkg::TAG_PREV_BUSY : '0;

    assign need_calc = ((NW'(cmd.request_size) + NW'(3)) & ~NW'(3)) + NW'(4);
    assign free_h    = PW'(cmd.payload_offset >> 2) - PW'(1);
    assign free_ok   = (cmd.payload_offset[1:0] == 2'b00)
                    && (cmd.payload_offset[OW-1:2] != '0)
                    && (PW'(cmd.payload_offset) < HB_POS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bfa_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        need_reg       <= need_next;
        best_reg       <= best_next;
        best_diff_reg  <= best_diff_next;
        best_pred_reg  <= best_pred_next;
        pred_reg       <= pred_next;
        found_reg      <= found_next;
        nxt_reg        <= nxt_next;
        h_reg          <= h_next;
        head_reg       <= head_next;
        foot_reg       <= foot_next;
        total_reg      <= total_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
    end

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        need_next       = need_reg;
        best_next       = best_reg;
        best_diff_next  = best_diff_reg;
        best_pred_next  = best_pred_reg;
        pred_next       = pred_reg;
        found_next      = found_reg;
        nxt_next        = nxt_reg;
        h_next          = h_reg;
        head_next       = head_reg;
        foot_next       = foot_reg;
        total_next      = total_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_addr         = '0;
        seq_ready       = 1'b0;
        resp            = '0;

        unique case (state_reg)
            bfa_pkg::ST_CLEAR: begin
                // Sweep the whole tag memory once after reset.
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                if (clr_cnt_reg == '0) begin
                    wr_data = HB_TAG | bfa_pkg::TAG_PREV_BUSY;
                end else if (clr_cnt_reg == LAST_ADDR) begin
                    wr_data = HB_TAG;
                end
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = bfa_pkg::ST_IDLE;
                end
            end

            bfa_pkg::ST_IDLE: begin
                seq_ready = 1'b1;
                if (start) begin
                    op_next         = cmd.opcode;
                    res_status_next = bfa_pkg::STATUS_FAIL;
                    res_off_next    = '0;
                    if (cmd.opcode == bfa_pkg::OP_ALLOC) begin
                        need_next  = need_calc;
                        pos_next   = '0;
                        pred_next  = 1'b1;
                        found_next = 1'b0;
                        rd_addr    = '0;
                        if (cmd.request_size == '0) begin
                            state_next = bfa_pkg::ST_RESP;
                        end else begin
                            state_next = bfa_pkg::ST_A_WALK;
                        end
                    end else begin
                        h_next  = free_h;
                        rd_addr = free_h[AW-1:0];
                        if (free_ok) begin
                            state_next = bfa_pkg::ST_F_HDR;
                        end else begin
                            state_next = bfa_pkg::ST_RESP;
                        end
                    end
                end
            end

            bfa_pkg::ST_A_WALK: begin
                // One block header per cycle; the next address comes straight
                // from the header just read.
                if (tag_size == '0) begin
                    state_next = bfa_pkg::ST_A_FIN;
                end else begin
                    if ((rd_data & bfa_pkg::TAG_BUSY) == '0) begin
                        if (fits && (!found_reg || fit_diff[TW-1:0] < best_diff_reg)) begin
                            found_next     = 1'b1;
                            best_next      = pos_reg[AW-1:0];
                            best_diff_next = fit_diff[TW-1:0];
                            best_pred_next = pred_reg;
                        end
                        pred_next = 1'b0;
                    end else begin
                        pred_next = 1'b1;
                    end
                    pos_next = pos_sum;
                    rd_addr  = pos_sum[AW-1:0];
                    if (pos_sum >= HW_POS) begin
                        state_next = bfa_pkg::ST_A_FIN;
                    end
                end
            end

            bfa_pkg::ST_A_FIN: begin
                if (!found_reg) begin
                    state_next = bfa_pkg::ST_RESP;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = best_reg;
                    wr_data  = TW'(need_reg) | bfa_pkg::TAG_BUSY
                             | (best_pred_reg ? bfa_pkg::TAG_PREV_BUSY : '0);
                    nxt_next = PW'(best_reg) + PW'(need_reg >> 2);
                    rd_addr  = nxt_next[AW-1:0];
                    res_status_next = bfa_pkg::STATUS_OK;
                    res_off_next    = OW'((PW'(best_reg) + PW'(1)) << 2);
                    state_next      = bfa_pkg::ST_A_SPLIT;
                end
            end

            bfa_pkg::ST_A_SPLIT: begin
                // The word after the allocated block either becomes the
                // remainder's header or just learns that its predecessor is busy.
                wr_en   = (nxt_reg < HW_POS);
                wr_addr = nxt_reg[AW-1:0];
                if (best_diff_reg != '0) begin
                    wr_data    = best_diff_reg | bfa_pkg::TAG_PREV_BUSY;
                    state_next = bfa_pkg::ST_A_FOOT;
                end else begin
                    wr_data    = rd_data | bfa_pkg::TAG_PREV_BUSY;
                    state_next = bfa_pkg::ST_RESP;
                end
            end

            bfa_pkg::ST_A_FOOT: begin
                wr_en      = (split_foot < HW_POS);
                wr_addr    = split_foot[AW-1:0];
                wr_data    = best_diff_reg | bfa_pkg::TAG_PREV_BUSY;
                state_next = bfa_pkg::ST_RESP;
            end

            bfa_pkg::ST_F_HDR: begin
                nxt_next = h_reg + tag_words;
                if (tag_size == '0 || (h_reg + tag_words) > HW_POS) begin
                    state_next = bfa_pkg::ST_RESP;
                end else begin
                    total_next = tag_size;
                    pred_next  = rd_data[1];
                    head_next  = h_reg;
                    wr_en      = 1'b1;
                    wr_addr    = h_reg[AW-1:0];
                    wr_data    = rd_data & ~bfa_pkg::TAG_BUSY;
                    if (h_reg != '0 && !rd_data[1]) begin
                        rd_addr    = AW'(h_reg - PW'(1));
                        state_next = bfa_pkg::ST_F_PREV;
                    end else begin
                        rd_addr    = nxt_next[AW-1:0];
                        state_next = bfa_pkg::ST_F_NEXT;
                    end
                end
            end

            bfa_pkg::ST_F_PREV: begin
                // Merge with the previous block through its footer.
                if (tag_size != '0 && tag_words <= h_reg) begin
                    pred_next  = rd_data[1];
                    total_next = total_reg + tag_size;
                    head_next  = h_reg - tag_words;
                end
                rd_addr    = nxt_reg[AW-1:0];
                state_next = bfa_pkg::ST_F_NEXT;
            end

            bfa_pkg::ST_F_NEXT: begin
                foot_next = nxt_reg - PW'(1);
                if (nxt_reg < HW_POS && !rd_data[0] && tag_size != '0
                    && nxt_end <= HW_POS) begin
                    total_next = total_reg + tag_size;
                    foot_next  = nxt_end - PW'(1);
                end
                state_next = bfa_pkg::ST_F_WH;
            end

            bfa_pkg::ST_F_WH: begin
                wr_en      = (head_reg < HW_POS);
                wr_addr    = head_reg[AW-1:0];
                wr_data    = total_reg + pred_tag;
                state_next = bfa_pkg::ST_F_WF;
            end

            bfa_pkg::ST_F_WF: begin
                wr_en      = (foot_reg < HW_POS);
                wr_addr    = foot_reg[AW-1:0];
                wr_data    = (total_reg & ~bfa_pkg::TAG_BUSY) + pred_tag;
                rd_addr    = foot_succ[AW-1:0];
                state_next = bfa_pkg::ST_F_CN;
            end

            bfa_pkg::ST_F_CN: begin
                wr_en           = (foot_succ < HW_POS);
                wr_addr         = foot_succ[AW-1:0];
                wr_data         = rd_data & ~bfa_pkg::TAG_PREV_BUSY;
                res_status_next = bfa_pkg::STATUS_OK;
                res_off_next    = '0;
                state_next      = bfa_pkg::ST_RESP;
            end

            bfa_pkg::ST_RESP: begin
                resp.valid  = 1'b1;
                resp.status = res_status_reg;
                resp.offset = res_off_reg;
                if (out_free) begin
                    state_next = bfa_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bfa_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_no_write_in_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bfa_pkg::ST_RESP || state_reg == bfa_pkg::ST_IDLE) |-> !wr_en)
        else $error("tag memory written while no operation is running");

    a_start_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && seq_ready) |=> (state_reg != bfa_pkg::ST_IDLE))
        else $error("accepted word did not start an operation");

    a_free_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (resp.valid && op_reg == bfa_pkg::OP_FREE) |-> (resp.offset == '0))
        else $error("free reported a nonzero offset");

    a_alloc_offset_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (resp.valid && op_reg == bfa_pkg::OP_ALLOC && resp.status == bfa_pkg::STATUS_OK)
        |-> (resp.offset[1:0] == 2'b00))
        else $error("allocated offset is not word aligned");
`endif

endmodule

// File: src/best_fit_boundary_tag_allocator_core.sv
// Best-fit boundary-tag heap allocator: top level with handshake and result register.
`timescale 1ns / 1ps

// Allocates and frees blocks in a heap of HEAP_WORDS 4-byte words kept as an
// implicit list of tagged blocks in a single-port-read tag memory. One word is
// handled at a time and s_ready is low while it runs. An allocate walks every
// block header at one header per cycle through the tag memory's read port; an
// allocate that finds no fit still walks the whole list. A free with a broken
// header is rejected once its header is read, and a request with zero size or
// a bad offset is rejected at once. The last step of every request waits while
// the output register is full and m_ready is low. After reset the tag memory
// is initialized by a pass over all HEAP_WORDS words, during which no word is
// accepted. The result sits in an output register, so the next word is
// accepted while the previous result waits.
module best_fit_boundary_tag_allocator_core #(
    parameter int HEAP_WORDS = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_opcode,
    input  logic [bfa_pkg::REQ_W-1:0] s_request_size,
    input  logic [bfa_pkg::OFF_W-1:0] s_payload_offset,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_status,
    output logic [bfa_pkg::OFF_W-1:0] m_result_offset
);

    localparam int AW = $clog2(HEAP_WORDS);

    bfa_pkg::bfa_cmd_t  cmd;
    bfa_pkg::bfa_resp_t resp;
    logic                      seq_ready;
    logic                      out_free;
    logic                      load;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [bfa_pkg::TAG_W-1:0] wr_data;
    logic [AW-1:0]             rd_addr;
    logic [bfa_pkg::TAG_W-1:0] rd_data;

    logic                      m_valid_reg, m_valid_next;
    logic                      m_status_reg, m_status_next;
    logic [bfa_pkg::OFF_W-1:0] m_offset_reg, m_offset_next;

    assign cmd = {s_opcode, s_request_size, s_payload_offset};

    assign s_ready  = seq_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign load     = resp.valid && out_free;

    bfa_seq #(
        .HEAP_WORDS(HEAP_WORDS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid),
        .cmd       (cmd),
        .out_free  (out_free),
        .seq_ready (seq_ready),
        .resp      (resp),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    bfa_tag_ram #(
        .HEAP_WORDS(HEAP_WORDS)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_offset_next = m_offset_reg;
        if (load) begin
            m_valid_next  = 1'b1;
            m_status_next = resp.status;
            m_offset_next = resp.offset;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_offset_reg <= m_offset_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_result_offset = m_offset_reg;

endmodule
